>>> hdl/psp_pkg.sv
// Package for the progress sequence parser: payload structs, character and
// status codes, field limits. No dependencies; imported by every hdl file.
package psp_pkg;

  localparam int MAX_PERCENT      = 100;
  localparam int MAX_FIELD_DIGITS = 3;

  localparam int VALUE_W = 10;
  localparam int COUNT_W = $clog2(MAX_FIELD_DIGITS + 1);

  localparam logic [7:0] CHAR_FOUR = 8'h34;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_PREFIX  = 2'd1;
  localparam logic [1:0] STATUS_BAD_STATE   = 2'd2;
  localparam logic [1:0] STATUS_BAD_PERCENT = 2'd3;

  localparam logic [2:0] PROG_CLEAR         = 3'd0;
  localparam logic [2:0] PROG_NORMAL        = 3'd1;
  localparam logic [2:0] PROG_ERROR         = 3'd2;
  localparam logic [2:0] PROG_INDETERMINATE = 3'd3;
  localparam logic [2:0] PROG_PAUSED        = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } psp_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] shown_state;
    logic [6:0] shown_percent;
  } psp_out_t;

endpackage

>>> hdl/psp_in_reg.sv
// Input register of the progress sequence parser: holds one transfer until
// the parse stage takes it. Depends on psp_pkg.
module psp_in_reg
  import psp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  psp_in_t in_data,
  input  logic    advance,
  output logic    hold_valid,
  output psp_in_t hold_data
);

  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
  end

endmodule

>>> hdl/psp_core.sv
// Parse stage of the progress sequence parser: per-byte field parsing,
// end-of-payload check and the kept state and percentage. Depends on psp_pkg.
module psp_core
  import psp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  psp_in_t  item,
  output psp_out_t result
);

  localparam logic [1:0] PH_FOUR    = 2'd0;
  localparam logic [1:0] PH_SEMI    = 2'd1;
  localparam logic [1:0] PH_STATE   = 2'd2;
  localparam logic [1:0] PH_PERCENT = 2'd3;

  logic [1:0]         phase;
  logic [VALUE_W-1:0] state_value;
  logic [COUNT_W-1:0] state_count;
  logic [VALUE_W-1:0] percent_value;
  logic [COUNT_W-1:0] percent_count;
  logic [1:0]         error_latch;
  logic [2:0]         current_state;
  logic [6:0]         current_percent;

  logic [1:0]         phase_next;
  logic [VALUE_W-1:0] state_value_next;
  logic [COUNT_W-1:0] state_count_next;
  logic [VALUE_W-1:0] percent_value_next;
  logic [COUNT_W-1:0] percent_count_next;
  logic [1:0]         error_next;
  logic [2:0]         current_state_next;
  logic [6:0]         current_percent_next;
  logic [1:0]         final_status;

  logic               is_digit;
  logic [3:0]         digit;
  logic               state_full;
  logic               percent_full;
  logic               state_field_ok;
  logic               supplied;
  logic [6:0]         clamped;

  assign is_digit     = (item.payload_byte >= CHAR_ZERO) && (item.payload_byte <= CHAR_NINE);
  assign digit        = 4'(item.payload_byte - CHAR_ZERO);
  assign state_full   = state_count >= COUNT_W'(MAX_FIELD_DIGITS);
  assign percent_full = percent_count >= COUNT_W'(MAX_FIELD_DIGITS);

  // Per-byte parse; a latched error freezes everything until the last byte.
  always_comb begin
    phase_next         = phase;
    state_value_next   = state_value;
    state_count_next   = state_count;
    percent_value_next = percent_value;
    percent_count_next = percent_count;
    error_next         = error_latch;
    if (error_latch == STATUS_OK) begin
      unique case (phase)
        PH_FOUR: begin
          if (item.payload_byte == CHAR_FOUR) phase_next = PH_SEMI;
          else error_next = STATUS_BAD_PREFIX;
        end
        PH_SEMI: begin
          if (item.payload_byte == CHAR_SEMI) phase_next = PH_STATE;
          else error_next = STATUS_BAD_PREFIX;
        end
        PH_STATE: begin
          if (is_digit) begin
            if (state_full) begin
              error_next = STATUS_BAD_STATE;
            end else begin
              state_value_next = (state_value << 3) + (state_value << 1)
                                 + VALUE_W'(digit);
              state_count_next = state_count + COUNT_W'(1);
            end
          end else if (item.payload_byte == CHAR_SEMI) begin
            if (state_count != '0 && state_value <= VALUE_W'(PROG_PAUSED)) begin
              phase_next = PH_PERCENT;
            end else begin
              error_next = STATUS_BAD_STATE;
            end
          end else begin
            error_next = STATUS_BAD_STATE;
          end
        end
        default: begin
          if (!is_digit || percent_full) begin
            error_next = STATUS_BAD_PERCENT;
          end else begin
            percent_value_next = (percent_value << 3) + (percent_value << 1)
                                 + VALUE_W'(digit);
            percent_count_next = percent_count + COUNT_W'(1);
          end
        end
      endcase
    end
  end

  // End-of-payload check on the values after this byte.
  assign state_field_ok = (state_count_next != '0)
                          && (state_value_next <= VALUE_W'(PROG_PAUSED));
  assign supplied = (phase_next == PH_PERCENT) && (percent_count_next != '0);
  assign clamped  = (percent_value_next > VALUE_W'(MAX_PERCENT)) ?
                    7'(MAX_PERCENT) : percent_value_next[6:0];

  always_comb begin
    final_status         = error_next;
    current_state_next   = current_state;
    current_percent_next = current_percent;
    priority if (error_next != STATUS_OK) begin
      final_status = error_next;
    end else if (phase_next == PH_FOUR || phase_next == PH_SEMI) begin
      final_status = STATUS_BAD_PREFIX;
    end else if (phase_next == PH_STATE && !state_field_ok) begin
      final_status = STATUS_BAD_STATE;
    end else begin
      final_status       = STATUS_OK;
      current_state_next = state_value_next[2:0];
      unique case (state_value_next[2:0])
        PROG_CLEAR:  current_percent_next = '0;
        PROG_NORMAL: current_percent_next = supplied ? clamped : '0;
        PROG_ERROR, PROG_PAUSED: begin
          if (supplied) current_percent_next = clamped;
        end
        default:     current_percent_next = current_percent;
      endcase
    end
  end

  assign result.status        = final_status;
  assign result.shown_state   = current_state_next;
  assign result.shown_percent = current_percent_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FOUR;
      state_value     <= '0;
      state_count     <= '0;
      percent_value   <= '0;
      percent_count   <= '0;
      error_latch     <= STATUS_OK;
      current_state   <= PROG_CLEAR;
      current_percent <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        phase           <= PH_FOUR;
        state_value     <= '0;
        state_count     <= '0;
        percent_value   <= '0;
        percent_count   <= '0;
        error_latch     <= STATUS_OK;
        current_state   <= current_state_next;
        current_percent <= current_percent_next;
      end else begin
        phase         <= phase_next;
        state_value   <= state_value_next;
        state_count   <= state_count_next;
        percent_value <= percent_value_next;
        percent_count <= percent_count_next;
        error_latch   <= error_next;
      end
    end
  end

endmodule

>>> hdl/psp_out_reg.sv
// Result register of the progress sequence parser: holds one result until
// the downstream side takes it. Depends on psp_pkg.
module psp_out_reg
  import psp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  psp_out_t load_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psp_out_t out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

>>> hdl/progress_sequence_parser_top.sv
// Top level of the progress sequence parser: input register, parse stage,
// result register. Depends on psp_pkg, psp_in_reg, psp_core, psp_out_reg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | sink      | in_valid / in_ready  | psp_in_t  (byte, last mark)
//   out     | source    | out_valid / out_ready| psp_out_t (status, state, %)
//
// One byte per cycle while no last byte waits on a full result slot: the
// parse stage consumes the held byte, and a last byte writes its result into
// the result register as it is consumed, after passing the input register.
// Only a last byte needs a free result slot; other bytes advance even while
// a result waits. Reset (rst, synchronous) drops held items and returns to
// the prefix phase with state clear and percentage zero.
module progress_sequence_parser_top
  import psp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  psp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psp_out_t out_data
);

  logic     hold_valid;
  psp_in_t  hold_data;
  logic     advance;
  psp_out_t result;

  // Advance the held byte unless it is a last byte and the result slot
  // stays full this cycle.
  assign advance = hold_valid && (!hold_data.last_byte || !out_valid || out_ready);

  psp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  psp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_data),
    .result (result)
  );

  psp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && hold_data.last_byte),
    .load_data (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hdl/psp_checker.sv
// Port-level checks for the progress sequence parser, bound to the top
// level. Depends on psp_pkg and progress_sequence_parser_top.
module psp_checker
  import psp_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input psp_out_t out_data
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.shown_percent <= 7'(MAX_PERCENT))
    else $error("percentage above limit");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.shown_state == PROG_CLEAR |-> out_data.shown_percent == 7'd0)
    else $error("clear state with nonzero percentage");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.shown_state <= PROG_PAUSED)
    else $error("shown state outside known codes");

endmodule

bind progress_sequence_parser_top psp_checker u_psp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for progress_sequence_parser_top: sends progress payloads byte by byte,
// predicts each status/state/percent report and checks it field by field.
// Depends on psp_pkg and the parser sources under hdl.
module testbench;
  import psp_pkg::*;

  // Where the predictor stands inside the payload
  typedef enum logic [1:0] {SEEK_FOUR, SEEK_SEMI, IN_STATE, IN_PERCENT} scan_phase_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  psp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  psp_out_t out_data;

  progress_sequence_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predictor state: the payload being scanned and the progress kept across payloads
  scan_phase_t        scan_phase;
  logic [VALUE_W-1:0] state_acc;
  logic [VALUE_W-1:0] percent_acc;
  int                 state_digits;
  int                 percent_digits;
  logic [1:0]         first_error;
  logic [2:0]         kept_state;
  logic [6:0]         kept_percent;

  psp_out_t   expected_reports[$];  // reports owed by the DUT, oldest first
  logic [7:0] payload_buf[$];       // payload under construction
  int         error_count = 0;
  int         bytes_sent = 0;
  bit         calm_sender = 1'b0;   // when set, send back to back with no gaps

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic bit state_field_ok();
    return state_digits != 0 && state_acc <= PROG_PAUSED;
  endfunction

  function automatic int digits_of(int v);
    return (v < 10) ? 1 : ((v < 100) ? 2 : 3);
  endfunction

  task automatic clear_scan();
    scan_phase     = SEEK_FOUR;
    state_acc      = '0;
    percent_acc    = '0;
    state_digits   = 0;
    percent_digits = 0;
    first_error    = STATUS_OK;
  endtask

  // Advance the predictor by one accepted byte; on the last byte queue the report.
  task automatic predict_report(psp_in_t item);
    logic [7:0] c;
    logic [6:0] pct;
    bit         supplied;
    c = item.payload_byte;
    // The first error wins: ignore everything after it until the last byte
    if (first_error == STATUS_OK) begin
      unique case (scan_phase)
        SEEK_FOUR: begin
          if (c == CHAR_FOUR) scan_phase = SEEK_SEMI;
          else first_error = STATUS_BAD_PREFIX;
        end
        SEEK_SEMI: begin
          if (c == CHAR_SEMI) scan_phase = IN_STATE;
          else first_error = STATUS_BAD_PREFIX;
        end
        IN_STATE: begin
          if (is_digit(c)) begin
            if (state_digits >= MAX_FIELD_DIGITS) begin
              first_error = STATUS_BAD_STATE;
            end else begin
              state_acc = VALUE_W'(state_acc * 10 + (c - CHAR_ZERO));
              state_digits++;
            end
          end else if (c == CHAR_SEMI && state_field_ok()) begin
            scan_phase = IN_PERCENT;
          end else begin
            first_error = STATUS_BAD_STATE;
          end
        end
        default: begin
          // A further separator counts as a non-digit here
          if (!is_digit(c) || percent_digits >= MAX_FIELD_DIGITS) begin
            first_error = STATUS_BAD_PERCENT;
          end else begin
            percent_acc = VALUE_W'(percent_acc * 10 + (c - CHAR_ZERO));
            percent_digits++;
          end
        end
      endcase
    end
    if (!item.last_byte) return;
    if (first_error == STATUS_OK) begin
      if (scan_phase == SEEK_FOUR || scan_phase == SEEK_SEMI) begin
        first_error = STATUS_BAD_PREFIX;
      end else if (scan_phase == IN_STATE && !state_field_ok()) begin
        first_error = STATUS_BAD_STATE;
      end else begin
        // An empty percent field after the separator means no percent at all
        supplied = scan_phase == IN_PERCENT && percent_digits != 0;
        pct = (percent_acc > MAX_PERCENT) ? 7'(MAX_PERCENT) : percent_acc[6:0];
        unique case (state_acc)
          PROG_CLEAR:              kept_percent = '0;
          PROG_NORMAL:             kept_percent = supplied ? pct : '0;
          PROG_ERROR, PROG_PAUSED: if (supplied) kept_percent = pct;
          default:                 ;
        endcase
        kept_state = state_acc[2:0];
      end
    end
    // An error report carries the kept progress unchanged
    expected_reports.push_back(psp_out_t'{status: first_error, shown_state: kept_state,
                                          shown_percent: kept_percent});
    clear_scan();
  endtask

  // Send one byte. Valid drops only when a gap follows, so back-to-back
  // transfers keep it high without a second assignment in the same step.
  task automatic send_byte(logic [7:0] c, logic last);
    int      gap;
    psp_in_t item;
    item = psp_in_t'{payload_byte: c, last_byte: last};
    gap  = calm_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_report(item);
    bytes_sent++;
  endtask

  // Send the buffered payload, marking its final byte, and empty the buffer
  task automatic send_buffer();
    foreach (payload_buf[i]) send_byte(payload_buf[i], i == payload_buf.size() - 1);
    payload_buf.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) payload_buf.push_back(s[i]);
    send_buffer();
  endtask

  // Append a decimal number with leading zeros up to ndigits
  task automatic push_number(int value, int ndigits);
    for (int i = ndigits - 1; i >= 0; i--)
      payload_buf.push_back(CHAR_ZERO + 8'((value / (10 ** i)) % 10));
  endtask

  // Prefix errors, including a payload that ends inside the prefix
  task automatic test_prefix_errors();
    send_text("4");
    send_text("x");
    send_text("4x;1");
    send_text("44;1");
    payload_buf.push_back(8'hFF);
    send_buffer();
  endtask

  // Empty, over-long, out-of-range and non-digit state fields
  task automatic test_state_field();
    send_text("4;");
    send_text("4;5");
    send_text("4;0001");
    send_text("4;;5");
    send_text("4;1a");
    payload_buf = '{CHAR_FOUR, CHAR_SEMI, 8'h00};
    send_buffer();
  endtask

  // Every state code, some with a percent and some without, a clamp and an empty percent field
  task automatic test_state_codes();
    send_text("4;1;50");
    send_text("4;3");
    send_text("4;2;");
    send_text("4;4;250");
    send_text("4;2;7");
    send_text("4;0");
    send_text("4;004;100");
    send_text("4;1");
  endtask

  // Over-long percent, extra separator, non-digit in the percent field
  task automatic test_percent_field();
    send_text("4;1;1234");
    send_text("4;2;5;");
    send_text("4;4;9x");
    send_text("4;3;;");
  endtask

  // Mostly well-formed payloads with random content, plus noise and broken ones
  task automatic test_random_payloads();
    int kind;
    int st;
    int pct;
    int sel;
    int nd;
    while (bytes_sent < 1700) begin
      if ($urandom_range(0, 19) == 0) calm_sender = ~calm_sender;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 6)) payload_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        payload_buf.push_back(CHAR_FOUR);
        payload_buf.push_back(CHAR_SEMI);
        st = (kind >= 90 && kind < 95) ? $urandom_range(5, 999) : $urandom_range(0, 4);
        nd = (kind >= 95) ? MAX_FIELD_DIGITS + 1
                          : $urandom_range(digits_of(st), MAX_FIELD_DIGITS);
        push_number(st, nd);
        if ($urandom_range(0, 3) != 0) begin
          payload_buf.push_back(CHAR_SEMI);
          sel = $urandom_range(0, 9);
          if (sel < 6) pct = $urandom_range(0, MAX_PERCENT);
          else pct = $urandom_range(MAX_PERCENT + 1, 999);
          if (sel < 8) push_number(pct, $urandom_range(digits_of(pct), MAX_FIELD_DIGITS));
          else if (sel == 9) push_number(pct, MAX_FIELD_DIGITS + 1);
        end
        // Corrupt one byte anywhere in the payload
        if (kind >= 80 && kind < 90)
          payload_buf[$urandom_range(0, payload_buf.size() - 1)] = 8'($urandom_range(0, 255));
        // Cut the payload short
        if (kind >= 97) payload_buf = payload_buf[0:$urandom_range(0, payload_buf.size() - 2)];
      end
      send_buffer();
    end
    calm_sender = 1'b0;
  endtask

  function automatic void compare_report_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Check every result transfer against the oldest expected report
  always @(posedge clk) begin
    psp_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected report, expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        compare_report_field("status", 7'(want.status), 7'(out_data.status));
        compare_report_field("shown_state", 7'(want.shown_state), 7'(out_data.shown_state));
        compare_report_field("shown_percent", want.shown_percent, out_data.shown_percent);
      end
    end
  end

  // Result side: hold ready for a run, then stall; sometimes a long run with no stall
  initial begin
    int run;
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    clear_scan();
    kept_state   = PROG_CLEAR;
    kept_percent = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_prefix_errors();
    test_state_field();
    test_state_codes();
    test_percent_field();
    test_random_payloads();

    // Drop valid after the final transfer, drain the reports, then let the pipe settle
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
hdl/psp_pkg.sv
hdl/psp_in_reg.sv
hdl/psp_core.sv
hdl/psp_out_reg.sv
hdl/progress_sequence_parser_top.sv
hdl/psp_checker.sv
verif/testbench.sv
